@@ rtl/qfau_pkg.sv @@
// Shared types and constants for the binary128 arithmetic unit.
package qfau_pkg;

  localparam int BIAS       = 16383;
  localparam int EXP_MAX    = 32767;
  localparam int FRAC_BITS  = 112;
  localparam int EXP_W      = 19;
  localparam int F64_REBIAS = 15360;
  localparam int SUB_LIMIT  = -111;

  // Action codes
  localparam logic [3:0] ACT_ADD      = 4'd0;
  localparam logic [3:0] ACT_SUB      = 4'd1;
  localparam logic [3:0] ACT_MUL      = 4'd2;
  localparam logic [3:0] ACT_DIV      = 4'd3;
  localparam logic [3:0] ACT_SQRT     = 4'd4;
  localparam logic [3:0] ACT_CMP      = 4'd5;
  localparam logic [3:0] ACT_F64_F128 = 4'd6;
  localparam logic [3:0] ACT_F128_F64 = 4'd7;
  localparam logic [3:0] ACT_S64      = 4'd8;
  localparam logic [3:0] ACT_U64      = 4'd9;
  localparam logic [3:0] ACT_TO_I64   = 4'd10;
  localparam logic [3:0] ACT_S128     = 4'd11;
  localparam logic [3:0] ACT_U128     = 4'd12;
  localparam logic [3:0] ACT_TO_I128  = 4'd13;

  // Shared unit operations
  localparam logic [1:0] COP_ADD  = 2'd0;
  localparam logic [1:0] COP_MUL  = 2'd1;
  localparam logic [1:0] COP_PACK = 2'd2;

  // Compare codes
  localparam logic [1:0] ORD_EQ     = 2'd0;
  localparam logic [1:0] ORD_LT     = 2'd1;
  localparam logic [1:0] ORD_GT     = 2'd2;
  localparam logic [1:0] ORD_EQ_MAX = 2'd3;

  localparam logic [63:0] SIGN64       = 64'h8000000000000000;
  localparam logic [63:0] DIV_EST_OFS  = 64'h7FFE000000000000;
  localparam logic [63:0] SQRT_EST_OFS = 64'h1FFF800000000000;
  localparam logic [63:0] TWO_HI       = 64'h4000000000000000;
  localparam logic [63:0] ONE_HI       = 64'h3FFF000000000000;
  localparam logic [63:0] F64_INF      = 64'h7FF0000000000000;

  typedef struct packed {
    logic [3:0]  action;
    logic [63:0] a_high;
    logic [63:0] a_low;
    logic [63:0] b_high;
    logic [63:0] b_low;
  } in_t;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
    logic [1:0]  order_code;
  } out_t;

  typedef struct packed {
    logic         valid;
    logic [1:0]   op;
    logic [127:0] x;
    logic [127:0] y;
  } core_req_t;

  typedef struct packed {
    logic         done;
    logic [127:0] value;
  } core_rsp_t;

endpackage

@@ rtl/qfau_mul.sv @@
// Iterative 128x128 multiplier built on one 32x32 multiplier.
module qfau_mul (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [127:0] x,
  input  logic [127:0] y,
  output logic         done,
  output logic [255:0] prod
);

  logic         running;
  logic [3:0]   cnt;
  logic         pp_valid;
  logic         pp_last;
  logic [63:0]  pp;
  logic [2:0]   pp_sh;
  logic [255:0] acc;
  logic [31:0]  xs;
  logic [31:0]  ys;

  assign xs   = x[{cnt[3:2], 5'b0} +: 32];
  assign ys   = y[{cnt[1:0], 5'b0} +: 32];
  assign prod = acc;

  // Sequence the control: sixteen partial products, then drain the last one into the accumulator
  always_ff @(posedge clk) begin
    if (rst) begin
      running  <= 1'b0;
      cnt      <= '0;
      pp_valid <= 1'b0;
      pp_last  <= 1'b0;
      done     <= 1'b0;
    end else begin
      pp_valid <= running;
      done     <= pp_valid & pp_last;
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        pp_last <= (cnt == 4'd15);
        cnt     <= cnt + 4'd1;
        if (cnt == 4'd15) begin
          running <= 1'b0;
        end
      end
    end
  end

  // Form a partial product, then accumulate it at its column offset
  always_ff @(posedge clk) begin
    if (start) begin
      acc <= '0;
    end else if (pp_valid) begin
      acc <= acc + ({192'b0, pp} << {pp_sh, 5'b0});
    end
    if (running) begin
      pp    <= xs * ys;
      pp_sh <= {1'b0, cnt[3:2]} + {1'b0, cnt[1:0]};
    end
  end

endmodule

@@ rtl/qfau_core.sv @@
// Shared add, multiply and normalize unit for binary128 values.
module qfau_core (
  input  logic                 clk,
  input  logic                 rst,
  input  qfau_pkg::core_req_t  req,
  output qfau_pkg::core_rsp_t  rsp
);
  import qfau_pkg::*;

  localparam logic [2:0] C_IDLE = 3'd0;
  localparam logic [2:0] C_ADD  = 3'd1;
  localparam logic [2:0] C_MULW = 3'd2;
  localparam logic [2:0] C_NZ   = 3'd3;
  localparam logic [2:0] C_LZ   = 3'd4;
  localparam logic [2:0] C_FIN  = 3'd5;
  localparam logic [2:0] C_DONE = 3'd6;

  localparam int LZ_PAD = EXP_W - 7;

  logic [2:0]              state;
  logic [127:0]            xv, yv, fa, fb, m, t, result;
  logic signed [EXP_W-1:0] ea, eb, e;
  logic                    sa, sb, s;
  logic [6:0]              lz;

  logic [14:0]             xe15, ye15;
  logic                    mul_start, mul_done;
  logic [255:0]            prod;

  // add datapath
  logic                    swap;
  logic [127:0]            fbig, fsm, fsh, vbig, sum;
  logic signed [EXP_W-1:0] ebig, esm, d;
  logic                    sbig, ssm;

  // final pack datapath
  logic signed [EXP_W-1:0] en, sh;
  logic [127:0]            mn, ms;

  assign xe15      = req.x[126:112];
  assign ye15      = req.y[126:112];
  assign mul_start = (state == C_IDLE) && req.valid && (req.op == COP_MUL);

  qfau_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .x     (fa),
    .y     (fb),
    .done  (mul_done),
    .prod  (prod)
  );

  // Order the addends and align the smaller one
  always_comb begin
    swap = (eb > ea) || ((eb == ea) && (fb > fa));
    fbig = swap ? fb : fa;
    fsm  = swap ? fa : fb;
    ebig = swap ? eb : ea;
    esm  = swap ? ea : eb;
    sbig = swap ? sb : sa;
    ssm  = swap ? sa : sb;
    vbig = swap ? yv : xv;
    d    = ebig - esm;
    fsh  = fsm >> d[6:0];
    sum  = (sbig != ssm) ? (fbig - fsh) : (fbig + fsh);
  end

  // Rebase the exponent once the leading one sits at the top
  always_comb begin
    en = e - $signed({{LZ_PAD{1'b0}}, lz}) + EXP_W'(15);
    sh = EXP_W'(1) - en;
    mn = t >> 15;
    ms = mn >> sh[6:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
    end else begin
      unique case (state)
        C_IDLE: begin
          if (req.valid) begin
            xv <= req.x;
            yv <= req.y;
            fa <= {15'b0, |xe15, req.x[111:0]};
            fb <= {15'b0, |ye15, req.y[111:0]};
            ea <= (|xe15) ? $signed({4'b0, xe15}) : EXP_W'(1);
            eb <= (|ye15) ? $signed({4'b0, ye15}) : EXP_W'(1);
            sa <= req.x[127];
            sb <= req.y[127];
            m  <= req.x;
            e  <= EXP_W'(BIAS + FRAC_BITS);
            s  <= req.y[0];
            unique case (req.op)
              COP_ADD: state <= C_ADD;
              COP_MUL: state <= C_MULW;
              default: state <= C_NZ;
            endcase
          end
        end
        C_ADD: begin
          if (d >= EXP_W'(FRAC_BITS)) begin
            result <= vbig;
            state  <= C_DONE;
          end else begin
            m     <= sum;
            e     <= ebig;
            s     <= sbig;
            state <= C_NZ;
          end
        end
        C_MULW: begin
          if (mul_done) begin
            m     <= prod[239:112];
            e     <= ea + eb - EXP_W'(BIAS);
            s     <= sa ^ sb;
            state <= C_NZ;
          end
        end
        C_NZ: begin
          t  <= m;
          lz <= '0;
          if (m == '0) begin
            result <= '0;
            state  <= C_DONE;
          end else begin
            state <= C_LZ;
          end
        end
        C_LZ: begin
          // advance a byte at a time, then single bits
          priority if (t[127]) begin
            state <= C_FIN;
          end else if (t[127:120] == 8'd0) begin
            t  <= t << 8;
            lz <= lz + 7'd8;
          end else begin
            t  <= t << 1;
            lz <= lz + 7'd1;
          end
        end
        C_FIN: begin
          priority if (en >= EXP_W'(EXP_MAX)) begin
            result <= {s, 15'h7FFF, 112'b0};
          end else if (en <= EXP_W'(SUB_LIMIT)) begin
            result <= '0;
          end else if (en <= EXP_W'(0)) begin
            result <= {s, 15'b0, ms[111:0]};
          end else begin
            result <= {s, en[14:0], mn[111:0]};
          end
          state <= C_DONE;
        end
        C_DONE: begin
          state <= C_IDLE;
        end
        default: begin
          state <= C_IDLE;
        end
      endcase
    end
  end

  assign rsp.done  = (state == C_DONE);
  assign rsp.value = result;

endmodule

@@ rtl/quad_float_arith_unit.sv @@
// Top level of the binary128 arithmetic unit: sequencer, compare and conversions.
//
// Usage: drive cmd and raise start; the operation is taken at a rising edge
// where start is high and busy is low. busy stays high until the result is
// delivered. The result appears on rsp for exactly one cycle with done high
// and is taken at the edge that ends that cycle; the receiver cannot stall.
// Operations pass through the shared add/multiply/normalize unit, whose multiply
// runs 16 partial products of one 32x32 multiplier, and whose normalize loop
// moves the leading one up a byte at a time, then single bits. Unit operations:
//   compare, f64/f128 swaps, to-integer: none, computed directly
//   integer to f128: one
//   add/sub, mul: one
//   div: (3*NEWTON_STEPS + 1) unit operations
//   sqrt: (3*NEWTON_STEPS + 1) unit operations
// One operation is in flight at a time.
// Reset returns the sequencer and the shared unit to idle; an operation in
// progress is dropped and no result is delivered for it.
module quad_float_arith_unit #(
  parameter int NEWTON_STEPS = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  qfau_pkg::in_t   cmd,
  output logic            done,
  output qfau_pkg::out_t  rsp
);
  import qfau_pkg::*;

  localparam int ITER_W = $clog2(NEWTON_STEPS + 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_RUN    = 3'd1;
  localparam logic [2:0] S_WAIT   = 3'd2;
  localparam logic [2:0] S_DIRECT = 3'd3;
  localparam logic [2:0] S_OUT    = 3'd4;

  localparam logic [2:0] P_ONE = 3'd0;
  localparam logic [2:0] P_K   = 3'd1;
  localparam logic [2:0] P_SQ  = 3'd2;
  localparam logic [2:0] P_ADD = 3'd3;
  localparam logic [2:0] P_UPD = 3'd4;
  localparam logic [2:0] P_FIN = 3'd5;

  logic [2:0]        state, phase;
  logic [ITER_W-1:0] iter;
  logic [3:0]        act;
  logic [127:0]      a, b, q, k, t, r;
  logic [1:0]        code;

  core_req_t         creq;
  core_rsp_t         crsp;

  logic [127:0]      a_in, b_in, q_div, q_sqrt, sq_sh;
  logic [127:0]      two_v, one_v;
  logic              is_div;

  // direct-result logic
  logic [63:0]       v;
  logic [10:0]       ex11;
  logic [14:0]       ex15;
  logic signed [16:0] exd;
  logic [1:0]        cmp_code;

  assign a_in   = {cmd.a_high, cmd.a_low};
  assign b_in   = {cmd.b_high, cmd.b_low};
  assign two_v  = {TWO_HI, 64'b0};
  assign one_v  = {ONE_HI, 64'b0};
  assign is_div = (act == ACT_DIV);
  assign busy   = (state != S_IDLE);
  assign done   = (state == S_OUT);

  // Initial estimates for the reciprocal and square-root iterations
  always_comb begin
    q_div[127:64] = (((~cmd.b_high) + DIV_EST_OFS) & ~SIGN64) | (cmd.b_high & SIGN64);
    q_div[63:0]   = ~cmd.b_low;
    sq_sh         = {1'b0, cmd.a_high[62:0], cmd.a_low} >> 1;
    q_sqrt        = {(sq_sh[127:64] + SQRT_EST_OFS) | (cmd.a_high & SIGN64), sq_sh[63:0]};
  end

  function automatic logic [127:0] flip(input logic [127:0] x);
    flip = {~x[127], x[126:0]};
  endfunction

  // Truncate to a signed integer of 64 or 128 bits, saturating to the minimum
  function automatic logic [127:0] to_int(input logic [127:0] x, input logic wide);
    logic signed [16:0] ex;
    logic signed [16:0] shr, shl;
    logic [127:0]       f, mg;
    logic [127:0]       res;
    ex  = $signed({2'b0, x[126:112]}) - 17'sd16383;
    shr = 17'sd112 - ex;
    shl = ex - 17'sd112;
    f   = {15'b0, |x[126:112], x[111:0]};
    mg  = '0;
    res = '0;
    if (ex <= 17'sd0) begin
      mg  = (ex == 17'sd0) ? 128'd1 : 128'd0;
      res = x[127] ? (128'd0 - mg) : mg;
    end else if (wide ? (ex >= 17'sd128) : (ex >= 17'sd64)) begin
      res = wide ? {SIGN64, 64'b0} : {64'b0, SIGN64};
    end else begin
      mg  = (ex <= 17'sd112) ? (f >> shr[6:0]) : (f << shl[6:0]);
      res = x[127] ? (128'd0 - mg) : mg;
    end
    to_int = res;
  endfunction

  // Order two binary128 patterns
  always_comb begin
    if ((a[126:0] == '0) && (b[126:0] == '0)) begin
      cmp_code = ORD_EQ;
    end else if (a[127] != b[127]) begin
      cmp_code = a[127] ? ORD_LT : ORD_GT;
    end else if (a == b) begin
      cmp_code = (a[126:112] == 15'h7FFF) ? ORD_EQ_MAX : ORD_EQ;
    end else if (a > b) begin
      cmp_code = a[127] ? ORD_LT : ORD_GT;
    end else begin
      cmp_code = a[127] ? ORD_GT : ORD_LT;
    end
  end

  assign v    = a[63:0];
  assign ex11 = v[62:52];
  assign ex15 = (ex11 == 11'h7FF) ? 15'h7FFF : (15'(ex11) + 15'(F64_REBIAS));
  assign exd  = $signed({2'b0, a[126:112]}) - 17'(F64_REBIAS);

  // Select the shared unit's operation for the current phase
  always_comb begin
    creq.valid = (state == S_RUN);
    creq.op    = COP_MUL;
    creq.x     = q;
    creq.y     = t;
    unique case (phase)
      P_ONE: begin
        creq.x = a;
        creq.y = b;
        unique case (act)
          ACT_ADD: creq.op = COP_ADD;
          ACT_SUB: begin
            creq.op = COP_ADD;
            creq.y  = flip(b);
          end
          ACT_MUL: creq.op = COP_MUL;
          ACT_S64: begin
            creq.op = COP_PACK;
            creq.x  = v[63] ? {64'b0, (~v) + 64'd1} : {64'b0, v};
            creq.y  = {127'b0, v[63]};
          end
          ACT_S128: begin
            creq.op = COP_PACK;
            creq.x  = a[127] ? (128'd0 - a) : a;
            creq.y  = {127'b0, a[127]};
          end
          ACT_U64: begin
            creq.op = COP_PACK;
            creq.x  = {64'b0, v};
            creq.y  = '0;
          end
          default: begin
            creq.op = COP_PACK;
            creq.y  = '0;
          end
        endcase
      end
      P_K: begin
        creq.op = COP_ADD;
        creq.x  = a;
        creq.y  = one_v;
      end
      P_SQ: begin
        creq.y = is_div ? b : q;
      end
      P_ADD: begin
        creq.op = COP_ADD;
        creq.x  = is_div ? two_v : k;
        creq.y  = flip(t);
      end
      P_UPD: begin
        creq.y = t;
      end
      default: begin
        creq.x = a;
        creq.y = q;
      end
    endcase
  end

  qfau_core u_core (
    .clk (clk),
    .rst (rst),
    .req (creq),
    .rsp (crsp)
  );

  // Sequence one operation, through the shared unit or the direct-result logic
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= P_ONE;
      iter  <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            act  <= cmd.action;
            a    <= a_in;
            b    <= b_in;
            r    <= '0;
            code <= ORD_EQ;
            iter <= '0;
            priority if (cmd.action == ACT_DIV) begin
              q     <= q_div;
              phase <= P_SQ;
              state <= S_RUN;
            end else if (cmd.action == ACT_SQRT) begin
              q     <= q_sqrt;
              phase <= P_K;
              state <= S_RUN;
            end else if (cmd.action == ACT_ADD || cmd.action == ACT_SUB ||
                         cmd.action == ACT_MUL || cmd.action == ACT_S64 ||
                         cmd.action == ACT_U64 || cmd.action == ACT_S128 ||
                         cmd.action == ACT_U128) begin
              phase <= P_ONE;
              state <= S_RUN;
            end else begin
              state <= S_DIRECT;
            end
          end
        end
        S_RUN: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (crsp.done) begin
            state <= S_RUN;
            unique case (phase)
              P_ONE: begin
                r     <= crsp.value;
                state <= S_OUT;
              end
              P_K: begin
                k     <= crsp.value;
                phase <= P_SQ;
              end
              P_SQ: begin
                t     <= crsp.value;
                phase <= P_ADD;
              end
              P_ADD: begin
                t     <= crsp.value;
                phase <= P_UPD;
              end
              P_UPD: begin
                q    <= crsp.value;
                iter <= iter + ITER_W'(1);
                if (iter == ITER_W'(NEWTON_STEPS - 1)) begin
                  iter <= '0;
                  if (is_div) begin
                    phase <= P_FIN;
                  end else begin
                    r     <= crsp.value;
                    state <= S_OUT;
                  end
                end else begin
                  phase <= P_SQ;
                end
              end
              default: begin
                r     <= crsp.value;
                state <= S_OUT;
              end
            endcase
          end
        end
        S_DIRECT: begin
          unique case (act)
            ACT_CMP: code <= cmp_code;
            ACT_F64_F128: begin
              if (ex11 != 11'd0) begin
                r <= {v[63], ex15, v[51:4], v[3:0], 60'b0};
              end
            end
            ACT_F128_F64: begin
              priority if (exd <= 17'sd0) begin
                r <= '0;
              end else if (exd >= 17'sd2047) begin
                r <= {64'b0, F64_INF | (a[127:64] & SIGN64)};
              end else begin
                r <= {64'b0, a[127], exd[10:0], a[111:64], a[63:60]};
              end
            end
            ACT_TO_I64:  r <= {64'b0, 64'(to_int(a, 1'b0))};
            ACT_TO_I128: r <= to_int(a, 1'b1);
            default:     r <= '0;
          endcase
          state <= S_OUT;
        end
        S_OUT: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp.result_high = r[127:64];
  assign rsp.result_low  = r[63:0];
  assign rsp.order_code  = code;

  // The shared unit only answers an operation the sequencer waits on
  a_rsp_in_wait: assert property (@(posedge clk) disable iff (rst)
    crsp.done |-> (state == S_WAIT))
    else $error("shared unit answered outside the wait state");

  // The Newton counter stays inside the step count
  a_iter_range: assert property (@(posedge clk) disable iff (rst)
    iter <= ITER_W'(NEWTON_STEPS - 1))
    else $error("iteration counter out of range");

  // A result strobe lasts one cycle
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held longer than one cycle");

  // An accepted transfer makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted command did not raise busy");

endmodule

@@ tb/quad_float_arith_unit_test.sv @@
// Self-checking testbench for the binary128 arithmetic unit.
`timescale 1ns / 1ps

module quad_float_arith_unit_test;
  import qfau_pkg::*;

  localparam int ITEM_COUNT = 1350;
  localparam int TAIL_ITEMS = 200;
  localparam int STEPS      = 8;

  typedef struct {
    in_t  c;
    bit   typed;
    out_t want;
  } row_t;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic done;
  in_t  cmd;
  out_t rsp;

  out_t expected_results[$];
  int   mismatches;
  int   results_seen;
  int   items_sent;
  int   div_sqrt_sent;

  quad_float_arith_unit #(.NEWTON_STEPS(STEPS)) i_dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .done  (done),
    .rsp   (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #100ms;
    $display("Some tests failed");
    $finish;
  end

  // ---- binary128 arithmetic, truncating ----

  function automatic int top_bit(logic [127:0] m);
    for (int i = 127; i > 0; i--) begin
      if (m[i]) return i;
    end
    return 0;
  endfunction

  // Scale m by 2^(e - BIAS - FRAC_BITS) and encode with sign s
  function automatic logic [127:0] normalize(logic [127:0] m, int e, logic s);
    int p;
    if (m == '0) return '0;
    p = top_bit(m);
    if (p > FRAC_BITS) begin
      m = m >> (p - FRAC_BITS);
      e += p - FRAC_BITS;
    end else begin
      m = m << (FRAC_BITS - p);
      e -= FRAC_BITS - p;
    end
    if (e >= EXP_MAX) return {s, 15'h7fff, 112'b0};
    if (e <= 0) begin
      if (e <= SUB_LIMIT) return '0;
      m = m >> (1 - e);
      return {s, 15'b0, m[111:0]};
    end
    return {s, e[14:0], m[111:0]};
  endfunction

  function automatic logic [127:0] frac_of(logic [127:0] v);
    return {15'b0, v[126:112] != 15'b0, v[111:0]};
  endfunction

  function automatic int exp_of(logic [127:0] v);
    return (v[126:112] == 15'b0) ? 1 : int'(v[126:112]);
  endfunction

  function automatic logic [127:0] flip_sign(logic [127:0] v);
    return {~v[127], v[126:0]};
  endfunction

  function automatic logic [127:0] f128_add(logic [127:0] a, logic [127:0] b);
    logic [127:0] fa, fb, t;
    int ea, eb, d;
    fa = frac_of(a);
    fb = frac_of(b);
    ea = exp_of(a);
    eb = exp_of(b);
    if (eb > ea || (eb == ea && fb > fa)) begin
      t = a; a = b; b = t;
      t = fa; fa = fb; fb = t;
      d = ea; ea = eb; eb = d;
    end
    d = ea - eb;
    if (d >= FRAC_BITS) return a;
    fb = fb >> d;
    return normalize((a[127] != b[127]) ? fa - fb : fa + fb, ea, a[127]);
  endfunction

  function automatic logic [127:0] f128_mul(logic [127:0] a, logic [127:0] b);
    logic [255:0] prod;
    prod = {128'b0, frac_of(a)} * {128'b0, frac_of(b)};
    return normalize(prod[239:112], exp_of(a) + exp_of(b) - BIAS, a[127] ^ b[127]);
  endfunction

  // Reciprocal by Newton steps from an exponent-flip estimate
  function automatic logic [127:0] f128_div(logic [127:0] a, logic [127:0] b);
    logic [127:0] q;
    q[127:64] = ((~b[127:64] + DIV_EST_OFS) & ~SIGN64) | (b[127:64] & SIGN64);
    q[63:0]   = ~b[63:0];
    for (int i = 0; i < STEPS; i++)
      q = f128_mul(q, f128_add({TWO_HI, 64'b0}, flip_sign(f128_mul(q, b))));
    return f128_mul(a, q);
  endfunction

  function automatic logic [127:0] f128_sqrt(logic [127:0] a);
    logic [127:0] q, k;
    k = f128_add(a, {ONE_HI, 64'b0});
    q = {1'b0, a[126:0]} >> 1;
    q[127:64] = (q[127:64] + SQRT_EST_OFS) | (a[127:64] & SIGN64);
    for (int i = 0; i < STEPS; i++)
      q = f128_mul(q, f128_add(k, flip_sign(f128_mul(q, q))));
    return q;
  endfunction

  function automatic logic [1:0] f128_order(logic [127:0] a, logic [127:0] b);
    if (a[126:0] == '0 && b[126:0] == '0) return ORD_EQ;
    if (a[127] != b[127]) return a[127] ? ORD_LT : ORD_GT;
    if (a == b) return (a[126:112] == 15'h7fff) ? ORD_EQ_MAX : ORD_EQ;
    if (a > b) return a[127] ? ORD_LT : ORD_GT;
    return a[127] ? ORD_GT : ORD_LT;
  endfunction

  // Truncate toward zero; out of range gives the most negative integer
  function automatic logic [127:0] f128_to_int(logic [127:0] a, int width);
    logic [127:0] f;
    int ex;
    ex = int'(a[126:112]) - BIAS;
    f = frac_of(a);
    if (ex <= 0) f = (ex == 0) ? 128'd1 : 128'd0;
    else if (ex >= width) return (width == 64) ? {64'b0, SIGN64} : {SIGN64, 64'b0};
    else if (ex <= FRAC_BITS) f = f >> (FRAC_BITS - ex);
    else f = f << (ex - FRAC_BITS);
    return a[127] ? -f : f;
  endfunction

  function automatic out_t predict_result(in_t c);
    out_t o;
    logic [127:0] a, b, r;
    logic [63:0] v;
    int ex;
    a = {c.a_high, c.a_low};
    b = {c.b_high, c.b_low};
    v = c.a_low;
    r = '0;
    o.order_code = ORD_EQ;
    case (c.action)
      ACT_ADD:  r = f128_add(a, b);
      ACT_SUB:  r = f128_add(a, flip_sign(b));
      ACT_MUL:  r = f128_mul(a, b);
      ACT_DIV:  r = f128_div(a, b);
      ACT_SQRT: r = f128_sqrt(a);
      ACT_CMP:  o.order_code = f128_order(a, b);
      ACT_F64_F128: begin
        ex = int'(v[62:52]);
        if (ex != 0) begin
          ex = (ex == 2047) ? EXP_MAX : ex + F64_REBIAS;
          r = {v[63], ex[14:0], v[51:4], v[3:0], 60'b0};
        end
      end
      ACT_F128_F64: begin
        ex = int'(c.a_high[62:48]) - F64_REBIAS;
        if (ex >= 2047) r[63:0] = F64_INF | (c.a_high & SIGN64);
        else if (ex > 0) r[63:0] = {c.a_high[63], ex[10:0], c.a_high[47:0], c.a_low[63:60]};
      end
      ACT_S64: r = v[63] ? normalize({64'b0, -v}, BIAS + FRAC_BITS, 1'b1)
                         : normalize({64'b0, v}, BIAS + FRAC_BITS, 1'b0);
      ACT_U64: r = normalize({64'b0, v}, BIAS + FRAC_BITS, 1'b0);
      ACT_TO_I64: begin
        r = f128_to_int(a, 64);
        r[127:64] = '0;
      end
      ACT_S128: r = a[127] ? normalize(-a, BIAS + FRAC_BITS, 1'b1)
                           : normalize(a, BIAS + FRAC_BITS, 1'b0);
      ACT_U128:    r = normalize(a, BIAS + FRAC_BITS, 1'b0);
      ACT_TO_I128: r = f128_to_int(a, 128);
      default: r = '0;
    endcase
    o.result_high = r[127:64];
    o.result_low  = r[63:0];
    return o;
  endfunction

  // ---- stimulus ----

  function automatic row_t mk_row(logic [3:0] act, logic [63:0] ah, logic [63:0] al,
                                  logic [63:0] bh, logic [63:0] bl, bit typed,
                                  logic [63:0] rh, logic [63:0] rl, logic [1:0] code);
    row_t r;
    r.c.action = act;
    r.c.a_high = ah;
    r.c.a_low  = al;
    r.c.b_high = bh;
    r.c.b_low  = bl;
    r.typed    = typed;
    r.want.result_high = rh;
    r.want.result_low  = rl;
    r.want.order_code  = code;
    return r;
  endfunction

  // Mix of zeros, subnormals, max exponent, raw bits and moderate values
  function automatic logic [127:0] rand_operand();
    logic [127:0] v;
    int mode;
    int e;
    v = {$urandom, $urandom, $urandom, $urandom};
    mode = $urandom_range(0, 9);
    case (mode)
      0: v = {v[127], 127'b0};
      1: v[126:112] = 15'b0;
      2: ;
      3: v[126:112] = 15'h7fff;
      default: begin
        e = BIAS + $urandom_range(0, 80) - 40;
        v[126:112] = e[14:0];
      end
    endcase
    return v;
  endfunction

  function automatic logic [3:0] rand_action();
    int w;
    w = $urandom_range(0, 99);
    if (w < 8) return ACT_DIV;
    if (w < 16) return ACT_SQRT;
    return 4'($urandom_range(0, 15));
  endfunction

  // Hold cmd with start high until the unit takes it
  task automatic transfer(in_t c, out_t want);
    cmd   <= c;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    expected_results.push_back(want);
    items_sent++;
    if (c.action == ACT_DIV || c.action == ACT_SQRT) div_sqrt_sent++;
  endtask

  task automatic maybe_idle(bit allowed);
    if (allowed && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  // ---- result check ----

  always @(posedge clk) begin
    out_t want;
    if (!rst && done) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result %h_%h code %0d",
                   rsp.result_high, rsp.result_low, rsp.order_code);
      end else begin
        want = expected_results.pop_front();
        if (rsp.result_high !== want.result_high || rsp.result_low !== want.result_low ||
            rsp.order_code !== want.order_code) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: result %0d: expected %h_%h code %0d, got %h_%h code %0d",
                     results_seen, want.result_high, want.result_low, want.order_code,
                     rsp.result_high, rsp.result_low, rsp.order_code);
        end
      end
    end
  end

  initial begin
    row_t plan[27];
    in_t  c;
    logic [127:0] a, b;
    bit idle_phase;

    mismatches    = 0;
    results_seen  = 0;
    items_sent    = 0;
    div_sqrt_sent = 0;
    rst   = 1'b1;
    start = 1'b0;
    cmd   = '0;

    plan[0]  = mk_row(ACT_ADD, ONE_HI, 0, ONE_HI, 0, 1, TWO_HI, 0, ORD_EQ);
    plan[1]  = mk_row(ACT_SUB, ONE_HI, 0, ONE_HI, 0, 1, 0, 0, ORD_EQ);
    plan[2]  = mk_row(ACT_MUL, 64'h7FFE_FFFF_FFFF_FFFF, '1, TWO_HI, 0, 1,
                      64'h7FFF_0000_0000_0000, 0, ORD_EQ);
    plan[3]  = mk_row(ACT_MUL, 64'h0001_0000_0000_0000, 0, 64'h0001_0000_0000_0000, 0, 1,
                      0, 0, ORD_EQ);
    plan[4]  = mk_row(ACT_ADD, 64'h0000_FFFF_FFFF_FFFF, '1, 64'h8000_0000_0000_0001, 5, 0,
                      0, 0, ORD_EQ);
    plan[5]  = mk_row(ACT_ADD, ONE_HI, 0, 64'h3F37_0000_0000_0000, 0, 1, ONE_HI, 0, ORD_EQ);
    plan[6]  = mk_row(ACT_DIV, ONE_HI, 0, 64'h4000_8000_0000_0000, 0, 0, 0, 0, ORD_EQ);
    plan[7]  = mk_row(ACT_DIV, ONE_HI, 0, 0, 0, 0, 0, 0, ORD_EQ);
    plan[8]  = mk_row(ACT_SQRT, 64'h4001_0000_0000_0000, 0, 0, 0, 0, 0, 0, ORD_EQ);
    plan[9]  = mk_row(ACT_SQRT, 64'hC001_0000_0000_0000, 0, 0, 0, 0, 0, 0, ORD_EQ);
    plan[10] = mk_row(ACT_CMP, 0, 0, SIGN64, 0, 1, 0, 0, ORD_EQ);
    plan[11] = mk_row(ACT_CMP, 64'h7FFF_0000_0000_0000, 1, 64'h7FFF_0000_0000_0000, 1, 1,
                      0, 0, ORD_EQ_MAX);
    plan[12] = mk_row(ACT_CMP, 64'hBFFF_0000_0000_0000, 0, ONE_HI, 0, 1, 0, 0, ORD_LT);
    plan[13] = mk_row(ACT_CMP, ONE_HI, 0, TWO_HI, 0, 1, 0, 0, ORD_LT);
    plan[14] = mk_row(ACT_F64_F128, 0, 1, 0, 0, 1, 0, 0, ORD_EQ);
    plan[15] = mk_row(ACT_F64_F128, 0, 64'h3FF0_0000_0000_000F, 0, 0, 0, 0, 0, ORD_EQ);
    plan[16] = mk_row(ACT_F64_F128, 0, F64_INF, 0, 0, 1, 64'h7FFF_0000_0000_0000, 0, ORD_EQ);
    plan[17] = mk_row(ACT_F128_F64, '1, '1, 0, 0, 1, 0, 64'hFFF0_0000_0000_0000, ORD_EQ);
    plan[18] = mk_row(ACT_F128_F64, ONE_HI, 0, 0, 0, 1, 0, 64'h3FF0_0000_0000_0000, ORD_EQ);
    plan[19] = mk_row(ACT_S64, 0, SIGN64, 0, 0, 0, 0, 0, ORD_EQ);
    plan[20] = mk_row(ACT_U64, 0, '1, 0, 0, 0, 0, 0, ORD_EQ);
    plan[21] = mk_row(ACT_TO_I64, 64'h7FFF_0000_0000_0000, 0, 0, 0, 1, 0, SIGN64, ORD_EQ);
    plan[22] = mk_row(ACT_S128, '1, '1, 0, 0, 0, 0, 0, ORD_EQ);
    plan[23] = mk_row(ACT_U128, '1, '1, 0, 0, 0, 0, 0, ORD_EQ);
    plan[24] = mk_row(ACT_TO_I128, 64'hBFFF_8000_0000_0000, 0, 0, 0, 0, 0, 0, ORD_EQ);
    plan[25] = mk_row(4'd14, '1, '1, '1, '1, 1, 0, 0, ORD_EQ);
    plan[26] = mk_row(4'd15, '1, '1, '1, '1, 1, 0, 0, ORD_EQ);

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed rows
    foreach (plan[i]) begin
      transfer(plan[i].c, plan[i].typed ? plan[i].want : predict_result(plan[i].c));
      maybe_idle(1'b1);
    end

    // Random items; idle allowed in two of every three stretches of 64 items, none in the tail
    for (int n = 0; n < ITEM_COUNT; n++) begin
      a = rand_operand();
      b = rand_operand();
      c.action = rand_action();
      if (c.action == ACT_CMP && $urandom_range(0, 2) == 0) b = a;
      if ((c.action == ACT_ADD || c.action == ACT_SUB) && $urandom_range(0, 3) == 0)
        b[126:112] = a[126:112] - 15'($urandom_range(0, 3));
      c.a_high = a[127:64];
      c.a_low  = a[63:0];
      c.b_high = b[127:64];
      c.b_low  = b[63:0];
      transfer(c, predict_result(c));
      idle_phase = ((n / 64) % 3) != 2 && n < ITEM_COUNT - TAIL_ITEMS;
      maybe_idle(idle_phase);
    end

    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    $display("Covered %0d operations (%0d divide or square root), %0d results checked.",
             items_sent, div_sqrt_sent, results_seen);
    $display("Mismatches: %0d", mismatches);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
